/* sv/evpms_pkg.sv */
// Types and constants shared by the powertrain mode sequencer files.
// No dependencies.
package evpms_pkg;

  localparam int unsigned SMP_W    = 12;  // brake and pedal sample field width
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LAT_W    = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Reciprocal scaling of pedal * full_scale by (2^SAMPLE_BITS - 1)
  localparam int unsigned X_W         = SMP_W + DUTY_W;
  localparam int unsigned RECIP_SHIFT = X_W + 1;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned PROD_W      = X_W + RECIP_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTD_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd5;

  localparam logic [SMP_W-1:0]  BRAKE_THR_RST = 12'd1000;
  localparam logic [DUTY_W-1:0] PWM_FS_RST    = 16'd1000;
  localparam logic [15:0]       RTD_HOLD_RST  = 16'd3000;
  localparam logic [15:0]       SOUND_RST     = 16'd3000;
  localparam logic [15:0]       DEBOUNCE_RST  = 16'd50;
  localparam logic [15:0]       SETTLE_RST    = 16'd50;

  // Mode codes reported in the result
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRECHARGE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEUTRAL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DRIVE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DISCHARGE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FAULT     = 3'd5;

  // Relay latch bit positions
  localparam int unsigned LAT_SHUT = 0;
  localparam int unsigned LAT_PRE  = 1;
  localparam int unsigned LAT_AIR  = 2;
  localparam int unsigned LAT_INV  = 3;
  localparam int unsigned LAT_DRV  = 4;
  localparam int unsigned LAT_BUZ  = 5;

  typedef struct packed {
    logic             start_button;
    logic             ready_button;
    logic             precharge_feedback;
    logic             air_feedback;
    logic             dc_link_charged;
    logic             dc_link_discharged;
    logic [SMP_W-1:0] brake_angle;
    logic [SMP_W-1:0] pedal_position;
  } req_t;

  typedef struct packed {
    logic              shutdown_relay;
    logic              precharge_relay;
    logic              air_relay;
    logic              inverter_enable;
    logic              drive_enable;
    logic              buzzer;
    logic [DUTY_W-1:0] pwm_duty;
    logic [MODE_W-1:0] mode;
  } res_t;

  typedef struct packed {
    logic [SMP_W-1:0] brake_threshold;
    logic [15:0]      rtd_hold_ticks;
    logic [15:0]      sound_ticks;
    logic [15:0]      debounce_ticks;
    logic [15:0]      settle_ticks;
  } cfg_t;

  // Sequencer outcome for one request
  typedef struct packed {
    logic [LAT_W-1:0]  lat;
    logic [MODE_W-1:0] mode;
    logic              duty_ld;
    logic              duty_clr;
  } stat_t;

endpackage

/* sv/evpms_if.sv */
// Valid/ready channels for requests and results of the mode sequencer.
// Depends on evpms_pkg.
interface evpms_req_if;
  logic              valid;
  logic              ready;
  evpms_pkg::req_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface evpms_res_if;
  logic              valid;
  logic              ready;
  evpms_pkg::res_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/evpms_ctrl.sv */
// Mode and wait sequencing: mode, phase, tick counter and relay latches.
// Depends on evpms_pkg.
module evpms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  evpms_pkg::req_t  req_i,
  input  evpms_pkg::cfg_t  cfg_i,
  output evpms_pkg::stat_t stat_o
);

  localparam logic [2:0] M_IDLE  = evpms_pkg::MODE_IDLE;
  localparam logic [2:0] M_PRE   = evpms_pkg::MODE_PRECHARGE;
  localparam logic [2:0] M_NEU   = evpms_pkg::MODE_NEUTRAL;
  localparam logic [2:0] M_DRV   = evpms_pkg::MODE_DRIVE;
  localparam logic [2:0] M_DIS   = evpms_pkg::MODE_DISCHARGE;
  localparam logic [2:0] M_FAULT = evpms_pkg::MODE_FAULT;

  localparam logic [2:0] PH_NONE   = 3'd0;
  localparam logic [2:0] PH_SETTLE = 3'd1;
  localparam logic [2:0] PH_REL    = 3'd2;
  localparam logic [2:0] PH_DEB    = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;
  localparam logic [2:0] PH_SOUND  = 3'd5;
  localparam logic [2:0] PH_RREL   = 3'd6;
  localparam logic [2:0] PH_RDEB   = 3'd7;

  logic [2:0]                      mode_q, mode_d;
  logic [2:0]                      phase_q, phase_d;
  logic [15:0]                     cnt_q, cnt_d;
  logic [evpms_pkg::LAT_W-1:0]     lat_q, lat_d;
  logic [15:0]                     cnt_inc;
  logic                            rtd_ok;
  logic                            enter;
  logic [2:0]                      enter_m;
  logic                            duty_ld, duty_clr;

  assign cnt_inc = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
  assign rtd_ok  = req_i.ready_button && (req_i.brake_angle > cfg_i.brake_threshold);

  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    lat_d    = lat_q;
    duty_ld  = 1'b0;
    duty_clr = 1'b0;
    enter    = 1'b0;
    enter_m  = M_IDLE;
    if (mode_q <= M_DIS) begin
      case (phase_q)
        PH_SETTLE: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.settle_ticks) phase_d = PH_NONE;
        end
        PH_REL: begin
          if (!req_i.start_button) begin
            phase_d = PH_DEB;
            cnt_d   = '0;
          end
        end
        PH_DEB: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.debounce_ticks) begin
            enter   = 1'b1;
            enter_m = (mode_q == M_IDLE) ? M_PRE : M_DIS;
          end
        end
        PH_HOLD: begin
          if (!rtd_ok) begin
            phase_d = PH_NONE;
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc >= cfg_i.rtd_hold_ticks) begin
              lat_d[evpms_pkg::LAT_BUZ] = 1'b1;
              phase_d = PH_SOUND;
              cnt_d   = '0;
            end
          end
        end
        PH_SOUND: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.sound_ticks) begin
            lat_d[evpms_pkg::LAT_BUZ] = 1'b0;
            phase_d = PH_RREL;
          end
        end
        PH_RREL: begin
          if (!req_i.ready_button) begin
            phase_d = PH_RDEB;
            cnt_d   = '0;
          end
        end
        PH_RDEB: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.debounce_ticks) begin
            enter   = 1'b1;
            enter_m = M_DRV;
          end
        end
        default: begin
          phase_d = PH_NONE;
          case (mode_q)
            M_IDLE: begin
              lat_d[evpms_pkg::LAT_SHUT] = 1'b1;
              if (req_i.start_button) phase_d = PH_REL;
            end
            M_PRE: begin
              if (!req_i.precharge_feedback) begin
                mode_d = M_FAULT;
                lat_d[evpms_pkg::LAT_SHUT] = 1'b1;
              end else if (req_i.dc_link_charged) begin
                enter   = 1'b1;
                enter_m = M_NEU;
              end
            end
            M_NEU: begin
              if (req_i.precharge_feedback || !req_i.air_feedback) begin
                mode_d = M_FAULT;
                lat_d[evpms_pkg::LAT_SHUT] = 1'b1;
              end else if (req_i.start_button) begin
                phase_d = PH_REL;
              end else if (rtd_ok) begin
                phase_d = PH_HOLD;
                cnt_d   = '0;
              end
            end
            M_DRV: begin
              lat_d[evpms_pkg::LAT_INV] = 1'b1;
              lat_d[evpms_pkg::LAT_DRV] = 1'b1;
              duty_ld = 1'b1;
              if (req_i.start_button) phase_d = PH_REL;
            end
            default: begin
              // discharge
              if (req_i.air_feedback) begin
                mode_d = M_FAULT;
                lat_d[evpms_pkg::LAT_SHUT] = 1'b1;
              end else if (req_i.dc_link_discharged) begin
                enter   = 1'b1;
                enter_m = M_IDLE;
              end
            end
          endcase
        end
      endcase

      if (enter) begin
        mode_d  = enter_m;
        phase_d = PH_NONE;
        cnt_d   = '0;
        case (enter_m)
          M_PRE: begin
            lat_d[evpms_pkg::LAT_PRE] = 1'b1;
            phase_d = PH_SETTLE;
          end
          M_NEU: begin
            lat_d[evpms_pkg::LAT_PRE] = 1'b0;
            lat_d[evpms_pkg::LAT_AIR] = 1'b1;
            phase_d = PH_SETTLE;
          end
          M_DIS: begin
            lat_d[evpms_pkg::LAT_SHUT] = 1'b0;
            lat_d[evpms_pkg::LAT_INV]  = 1'b0;
            lat_d[evpms_pkg::LAT_DRV]  = 1'b0;
            lat_d[evpms_pkg::LAT_AIR]  = 1'b0;
            duty_clr = 1'b1;
            phase_d  = PH_SETTLE;
          end
          default: begin
            phase_d = PH_NONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      phase_q <= PH_NONE;
      cnt_q   <= '0;
      lat_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      lat_q   <= lat_d;
    end
  end

  assign stat_o.lat      = lat_d;
  assign stat_o.mode     = mode_d;
  assign stat_o.duty_ld  = duty_ld;
  assign stat_o.duty_clr = duty_clr;

endmodule

/* sv/evpms_scale.sv */
// Divide of pedal * full_scale by (2^SAMPLE_BITS - 1): reciprocal multiply into a
// register, then a one-step remainder correction. Depends on evpms_pkg.
module evpms_scale #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic [evpms_pkg::X_W-1:0]     x_i,
  output logic [evpms_pkg::DUTY_W-1:0]  q_o
);

  localparam int unsigned     RW     = 33;
  localparam longint unsigned DIV    = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [evpms_pkg::RECIP_W-1:0] RECIP =
    evpms_pkg::RECIP_W'((64'd1 << evpms_pkg::RECIP_SHIFT) / DIV);
  localparam logic [RW-1:0]   DIV_R  = RW'(DIV);

  logic [evpms_pkg::PROD_W-1:0] prod_q;
  logic [evpms_pkg::X_W-1:0]    x_q;
  logic [evpms_pkg::DUTY_W-1:0] q0;
  logic [RW-1:0]                qd;
  logic [RW-1:0]                rem;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= evpms_pkg::PROD_W'(x_i) * evpms_pkg::PROD_W'(RECIP);
      x_q    <= x_i;
    end
  end

  // estimate is exact or one low
  assign q0  = prod_q[evpms_pkg::RECIP_SHIFT +: evpms_pkg::DUTY_W];
  assign qd  = (RW'(q0) << SAMPLE_BITS) - RW'(q0);
  assign rem = RW'(x_q) - qd;
  assign q_o = q0 + evpms_pkg::DUTY_W'(rem >= DIV_R);

endmodule

/* sv/ev_powertrain_mode_sequencer_unit.sv */
// Powertrain mode sequencer: one request per 1 ms tick, one result per request, in order.
// Takes a request every clock cycle unless results stall; each result goes through the
// input register, sequencer update with pedal multiply, reciprocal multiply and duty
// correction into the output register. Configuration is to be written only while no request
// is in flight (unenforced). Depends on evpms_pkg, evpms_if, evpms_ctrl and evpms_scale.
module ev_powertrain_mode_sequencer_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  evpms_req_if.sink                            req_i,
  evpms_res_if.source                          res_o,
  input  logic                                 cfg_we_i,
  input  logic [evpms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [evpms_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  localparam logic [evpms_pkg::SMP_W-1:0] SMP_MASK =
    (SAMPLE_BITS >= evpms_pkg::SMP_W) ? {evpms_pkg::SMP_W{1'b1}}
                                      : evpms_pkg::SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // configuration
  logic [evpms_pkg::SMP_W-1:0]  brake_thr_q;
  logic [evpms_pkg::DUTY_W-1:0] pwm_fs_q;
  logic [15:0]                  rtd_hold_q, sound_q, debounce_q, settle_q;
  evpms_pkg::cfg_t              cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_thr_q <= evpms_pkg::BRAKE_THR_RST;
      pwm_fs_q    <= evpms_pkg::PWM_FS_RST;
      rtd_hold_q  <= evpms_pkg::RTD_HOLD_RST;
      sound_q     <= evpms_pkg::SOUND_RST;
      debounce_q  <= evpms_pkg::DEBOUNCE_RST;
      settle_q    <= evpms_pkg::SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        evpms_pkg::CFG_BRAKE_THR: brake_thr_q <= cfg_data_i[evpms_pkg::SMP_W-1:0];
        evpms_pkg::CFG_PWM_FS:    pwm_fs_q    <= cfg_data_i;
        evpms_pkg::CFG_RTD_HOLD:  rtd_hold_q  <= cfg_data_i;
        evpms_pkg::CFG_SOUND:     sound_q     <= cfg_data_i;
        evpms_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        evpms_pkg::CFG_SETTLE:    settle_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.brake_threshold = brake_thr_q;
  assign cfg.rtd_hold_ticks  = rtd_hold_q;
  assign cfg.sound_ticks     = sound_q;
  assign cfg.debounce_ticks  = debounce_q;
  assign cfg.settle_ticks    = settle_q;

  // pipeline occupancy and advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || res_o.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign req_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= req_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: input register
  evpms_pkg::req_t req1_q;
  evpms_pkg::req_t req1_m;

  always_ff @(posedge clk_i) begin
    if (adv1 && req_i.valid) req1_q <= req_i.data;
  end

  always_comb begin
    req1_m                = req1_q;
    req1_m.brake_angle    = req1_q.brake_angle & SMP_MASK;
    req1_m.pedal_position = req1_q.pedal_position & SMP_MASK;
  end

  // stage 2: sequencer update and pedal product
  evpms_pkg::stat_t             stat;
  evpms_pkg::stat_t             stat2_q, stat3_q;
  logic [evpms_pkg::X_W-1:0]    x2_q;
  logic                         step2;

  assign step2 = adv2 && v1_q;

  evpms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step2),
    .req_i  (req1_m),
    .cfg_i  (cfg),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i) begin
    if (step2) begin
      stat2_q <= stat;
      x2_q    <= evpms_pkg::X_W'(req1_m.pedal_position) * evpms_pkg::X_W'(pwm_fs_q);
    end
  end

  // stage 3: reciprocal multiply
  logic                          step3;
  logic [evpms_pkg::DUTY_W-1:0]  q3;

  assign step3 = adv3 && v2_q;

  evpms_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i (clk_i),
    .ld_i  (step3),
    .x_i   (x2_q),
    .q_o   (q3)
  );

  always_ff @(posedge clk_i) begin
    if (step3) stat3_q <= stat2_q;
  end

  // stage 4: output register, duty held across requests
  logic                          step4;
  logic [evpms_pkg::LAT_W-1:0]   lat4_q;
  logic [evpms_pkg::MODE_W-1:0]  mode4_q;
  logic [evpms_pkg::DUTY_W-1:0]  duty_q;

  assign step4 = adv4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else if (step4) begin
      if (stat3_q.duty_clr)     duty_q <= '0;
      else if (stat3_q.duty_ld) duty_q <= q3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step4) begin
      lat4_q  <= stat3_q.lat;
      mode4_q <= stat3_q.mode;
    end
  end

  assign res_o.valid                = v4_q;
  assign res_o.data.shutdown_relay  = lat4_q[evpms_pkg::LAT_SHUT];
  assign res_o.data.precharge_relay = lat4_q[evpms_pkg::LAT_PRE];
  assign res_o.data.air_relay       = lat4_q[evpms_pkg::LAT_AIR];
  assign res_o.data.inverter_enable = lat4_q[evpms_pkg::LAT_INV];
  assign res_o.data.drive_enable    = lat4_q[evpms_pkg::LAT_DRV];
  assign res_o.data.buzzer          = lat4_q[evpms_pkg::LAT_BUZ];
  assign res_o.data.pwm_duty        = duty_q;
  assign res_o.data.mode            = mode4_q;

endmodule
